/* sv/mer_pkg.sv */
package mer_pkg;

  // Radius inputs are clamped to this value on start
  localparam int MAX_RADIUS = 255;

  // Command queue between the front and the back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [0:0] {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_SPAN  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_R1   = 2'd1,
    PH_R2   = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BK_WAIT,
    BK_EVAL,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {
    EM_OUTLINE,
    EM_FILL,
    EM_DONE
  } em_mode_t;

  // One queued command; squares of the clamped radii are precomputed
  typedef struct packed {
    logic        is_start;
    logic [9:0]  center_x;
    logic [9:0]  center_y;
    logic [7:0]  semi_x;
    logic [7:0]  semi_y;
    logic [15:0] sq_x;
    logic [15:0] sq_y;
    logic        fill_mode;
    logic [7:0]  colour;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* sv/mer_if.sv */
interface mer_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [9:0]  center_x;
  logic [9:0]  center_y;
  logic [7:0]  semi_x;
  logic [7:0]  semi_y;
  logic        fill_mode;
  logic [7:0]  colour;

  modport source (output valid, action, center_x, center_y, semi_x, semi_y,
                  fill_mode, colour, input ready);
  modport sink (input valid, action, center_x, center_y, semi_x, semi_y,
                fill_mode, colour, output ready);
endinterface

interface mer_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [11:0] pos_x;
  logic signed [11:0] pos_y;
  logic signed [11:0] end_y;
  logic [7:0]         colour_out;
  logic               last;

  modport source (output valid, kind, pos_x, pos_y, end_y, colour_out, last,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, end_y, colour_out, last,
                output ready);
endinterface

/* sv/mer_front.sv */
module mer_front (
  mer_in_if.sink          in_ch,
  input  mer_pkg::q_stat_t q_stat,
  output logic            q_push,
  output mer_pkg::cmd_t   q_cmd
);

  logic [7:0] rx_sat;
  logic [7:0] ry_sat;

  // clamp radii, square them for the back's setup multiplies
  always_comb begin
    rx_sat = (int'(in_ch.semi_x) > mer_pkg::MAX_RADIUS) ?
             8'(mer_pkg::MAX_RADIUS) : in_ch.semi_x;
    ry_sat = (int'(in_ch.semi_y) > mer_pkg::MAX_RADIUS) ?
             8'(mer_pkg::MAX_RADIUS) : in_ch.semi_y;
    q_cmd.is_start  = (in_ch.action == mer_pkg::ACT_START);
    q_cmd.center_x  = in_ch.center_x;
    q_cmd.center_y  = in_ch.center_y;
    q_cmd.semi_x    = rx_sat;
    q_cmd.semi_y    = ry_sat;
    q_cmd.sq_x      = 16'(rx_sat) * 16'(rx_sat);
    q_cmd.sq_y      = 16'(ry_sat) * 16'(ry_sat);
    q_cmd.fill_mode = in_ch.fill_mode;
    q_cmd.colour    = in_ch.colour;
  end

  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && !q_stat.full;

endmodule

/* sv/mer_queue.sv */
module mer_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mer_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output mer_pkg::cmd_t     head,
  output mer_pkg::q_stat_t  stat
);

  mer_pkg::cmd_t                  mem_r [mer_pkg::QDEPTH];
  logic [mer_pkg::QPTR_W-1:0]     wr_r, wr_nxt;
  logic [mer_pkg::QPTR_W-1:0]     rd_r, rd_nxt;
  logic [mer_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign stat.full  = (cnt_r == mer_pkg::QCNT_W'(mer_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == mer_pkg::QPTR_W'(mer_pkg::QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == mer_pkg::QPTR_W'(mer_pkg::QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

/* sv/mer_back.sv */
module mer_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mer_pkg::cmd_t    head,
  input  mer_pkg::q_stat_t q_stat,
  output logic             q_pop,
  mer_out_if.source        out_ch
);

  mer_pkg::bk_state_t state_r, state_nxt;
  mer_pkg::phase_t    phase_r, phase_nxt;
  mer_pkg::em_mode_t  mode_r, mode_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic               upd_r, upd_nxt;

  // latched ellipse parameters
  logic [9:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic [7:0]  ry_r, ry_nxt;
  logic [7:0]  colour_r, colour_nxt;
  logic        fill_r, fill_nxt, rzero_r, rzero_nxt;
  logic [17:0] rxsq2_r, rxsq2_nxt, rysq2_r, rysq2_nxt;
  logic signed [31:0] r2chy_r, r2chy_nxt, r2spy_r, r2spy_nxt;

  // walk state
  logic signed [11:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic signed [31:0] chx_r, chx_nxt, chy_r, chy_nxt, err_r, err_nxt;
  logic signed [31:0] spx_r, spx_nxt, spy_r, spy_nxt;

  // mirrored coordinates of the current point
  logic [11:0] xp_r, xp_nxt, xm_r, xm_nxt, yp_r, yp_nxt, ym_r, ym_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [11:0] opx_r, opx_nxt, opy_r, opy_nxt, oey_r, oey_nxt;
  logic [7:0]  ocol_r, ocol_nxt;
  logic        olast_r, olast_nxt;

  // setup products from the queued squares
  logic signed [9:0]  fx, fy;
  logic [24:0]        prod_spx, prod_spy2;
  logic signed [26:0] prod_chx, prod_chy2;

  logic signed [31:0] rxsq2_w, rysq2_w;
  logic signed [33:0] dec_r1, dec_r2;
  logic               out_free, at_last;

  assign fx        = 10'sd1 - $signed({1'b0, head.semi_x, 1'b0});
  assign fy        = 10'sd1 - $signed({1'b0, head.semi_y, 1'b0});
  assign prod_spx  = 25'({head.sq_y, 1'b0}) * 25'(head.semi_x);
  assign prod_spy2 = 25'({head.sq_x, 1'b0}) * 25'(head.semi_y);
  assign prod_chx  = 27'($signed({1'b0, head.sq_y})) * 27'(fx);
  assign prod_chy2 = 27'($signed({1'b0, head.sq_x})) * 27'(fy);

  assign rxsq2_w = {14'd0, rxsq2_r};
  assign rysq2_w = {14'd0, rysq2_r};
  assign dec_r1  = $signed({err_r[31], err_r, 1'b0}) + 34'(chx_r);
  assign dec_r2  = $signed({err_r[31], err_r, 1'b0}) + 34'(chy_r);

  assign out_free = !ov_r || out_ch.ready;

  always_comb begin
    case (mode_r)
      mer_pkg::EM_OUTLINE: at_last = (idx_r == 2'd3);
      mer_pkg::EM_FILL:    at_last = (idx_r == 2'd1);
      default:             at_last = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    upd_nxt    = upd_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    ry_nxt     = ry_r;
    colour_nxt = colour_r;
    fill_nxt   = fill_r;
    rzero_nxt  = rzero_r;
    rxsq2_nxt  = rxsq2_r;
    rysq2_nxt  = rysq2_r;
    r2chy_nxt  = r2chy_r;
    r2spy_nxt  = r2spy_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    chx_nxt    = chx_r;
    chy_nxt    = chy_r;
    err_nxt    = err_r;
    spx_nxt    = spx_r;
    spy_nxt    = spy_r;
    xp_nxt     = xp_r;
    xm_nxt     = xm_r;
    yp_nxt     = yp_r;
    ym_nxt     = ym_r;
    ov_nxt     = ov_r && !out_ch.ready;
    okind_nxt  = okind_r;
    opx_nxt    = opx_r;
    opy_nxt    = opy_r;
    oey_nxt    = oey_r;
    ocol_nxt   = ocol_r;
    olast_nxt  = olast_r;
    q_pop      = 1'b0;

    case (state_r)
      mer_pkg::BK_WAIT: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (head.is_start) begin
            cx_nxt     = head.center_x;
            cy_nxt     = head.center_y;
            ry_nxt     = head.semi_y;
            colour_nxt = head.colour;
            fill_nxt   = head.fill_mode;
            rzero_nxt  = (head.semi_x == 8'd0) && (head.semi_y == 8'd0);
            rxsq2_nxt  = {1'b0, head.sq_x, 1'b0};
            rysq2_nxt  = {1'b0, head.sq_y, 1'b0};
            r2chy_nxt  = 32'(prod_chy2);
            r2spy_nxt  = {7'd0, prod_spy2};
            ox_nxt     = {4'd0, head.semi_x};
            oy_nxt     = '0;
            chx_nxt    = 32'(prod_chx);
            chy_nxt    = {16'd0, head.sq_x};
            err_nxt    = '0;
            spx_nxt    = {7'd0, prod_spx};
            spy_nxt    = '0;
            phase_nxt  = mer_pkg::PH_R1;
          end else begin
            state_nxt = mer_pkg::BK_EVAL;
          end
        end
      end

      mer_pkg::BK_EVAL: begin
        xp_nxt = {2'b00, cx_r} + ox_r;
        xm_nxt = {2'b00, cx_r} - ox_r;
        yp_nxt = {2'b00, cy_r} + oy_r;
        ym_nxt = {2'b00, cy_r} - oy_r;
        idx_nxt  = '0;
        mode_nxt = fill_r ? mer_pkg::EM_FILL : mer_pkg::EM_OUTLINE;
        case (phase_r)
          mer_pkg::PH_R1: begin
            if (rzero_r) begin
              phase_nxt = mer_pkg::PH_DONE;
              state_nxt = mer_pkg::BK_EMIT;
            end else if (spx_r >= spy_r) begin
              oy_nxt    = oy_r + 12'sd1;
              spy_nxt   = spy_r + rxsq2_w;
              err_nxt   = err_r + chy_r;
              chy_nxt   = chy_r + rxsq2_w;
              upd_nxt   = 1'b1;
              state_nxt = mer_pkg::BK_EMIT;
            end else begin
              // crossed into the steep part; evaluate it next cycle
              ox_nxt    = '0;
              oy_nxt    = {4'd0, ry_r};
              chx_nxt   = {15'd0, rysq2_r[17:1]};
              chy_nxt   = r2chy_r;
              err_nxt   = '0;
              spx_nxt   = '0;
              spy_nxt   = r2spy_r;
              phase_nxt = mer_pkg::PH_R2;
            end
          end
          mer_pkg::PH_R2: begin
            if (spx_r <= spy_r) begin
              ox_nxt  = ox_r + 12'sd1;
              spx_nxt = spx_r + rysq2_w;
              err_nxt = err_r + chx_r;
              chx_nxt = chx_r + rysq2_w;
              upd_nxt = 1'b1;
            end else begin
              phase_nxt = mer_pkg::PH_DONE;
              mode_nxt  = mer_pkg::EM_DONE;
            end
            state_nxt = mer_pkg::BK_EMIT;
          end
          default: begin
            mode_nxt  = mer_pkg::EM_DONE;
            state_nxt = mer_pkg::BK_EMIT;
          end
        endcase
      end

      mer_pkg::BK_EMIT: begin
        // second half of the error update, off the output path
        if (upd_r) begin
          upd_nxt = 1'b0;
          if (phase_r == mer_pkg::PH_R1) begin
            if (dec_r1 > 34'sd0) begin
              ox_nxt  = ox_r - 12'sd1;
              spx_nxt = spx_r - rysq2_w;
              err_nxt = err_r + chx_r;
              chx_nxt = chx_r + rysq2_w;
            end
          end else begin
            if (dec_r2 > 34'sd0) begin
              oy_nxt  = oy_r - 12'sd1;
              spy_nxt = spy_r - rxsq2_w;
              err_nxt = err_r + chy_r;
              chy_nxt = chy_r + rxsq2_w;
            end
          end
        end
        if (out_free) begin
          ov_nxt    = 1'b1;
          ocol_nxt  = colour_r;
          olast_nxt = at_last;
          case (mode_r)
            mer_pkg::EM_OUTLINE: begin
              okind_nxt = mer_pkg::KIND_PIXEL;
              opx_nxt   = (idx_r == 2'd0 || idx_r == 2'd3) ? xp_r : xm_r;
              opy_nxt   = (idx_r == 2'd0 || idx_r == 2'd1) ? yp_r : ym_r;
              oey_nxt   = (idx_r == 2'd0 || idx_r == 2'd1) ? yp_r : ym_r;
            end
            mer_pkg::EM_FILL: begin
              okind_nxt = mer_pkg::KIND_SPAN;
              opx_nxt   = (idx_r == 2'd0) ? xp_r : xm_r;
              opy_nxt   = yp_r;
              oey_nxt   = ym_r;
            end
            default: begin
              okind_nxt = mer_pkg::KIND_DONE;
              opx_nxt   = '0;
              opy_nxt   = '0;
              oey_nxt   = '0;
            end
          endcase
          if (at_last) begin
            idx_nxt   = '0;
            state_nxt = mer_pkg::BK_WAIT;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end

      default: begin
        state_nxt = mer_pkg::BK_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mer_pkg::BK_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mer_pkg::PH_IDLE;
      mode_r   <= mer_pkg::EM_DONE;
      idx_r    <= '0;
      upd_r    <= 1'b0;
      ov_r     <= 1'b0;
      colour_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      mode_r   <= mode_nxt;
      idx_r    <= idx_nxt;
      upd_r    <= upd_nxt;
      ov_r     <= ov_nxt;
      colour_r <= colour_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    ry_r    <= ry_nxt;
    fill_r  <= fill_nxt;
    rzero_r <= rzero_nxt;
    rxsq2_r <= rxsq2_nxt;
    rysq2_r <= rysq2_nxt;
    r2chy_r <= r2chy_nxt;
    r2spy_r <= r2spy_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    chx_r   <= chx_nxt;
    chy_r   <= chy_nxt;
    err_r   <= err_nxt;
    spx_r   <= spx_nxt;
    spy_r   <= spy_nxt;
    xp_r    <= xp_nxt;
    xm_r    <= xm_nxt;
    yp_r    <= yp_nxt;
    ym_r    <= ym_nxt;
    okind_r <= okind_nxt;
    opx_r   <= opx_nxt;
    opy_r   <= opy_nxt;
    oey_r   <= oey_nxt;
    ocol_r  <= ocol_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.kind       = okind_r;
  assign out_ch.pos_x      = opx_r;
  assign out_ch.pos_y      = opy_r;
  assign out_ch.end_y      = oey_r;
  assign out_ch.colour_out = ocol_r;
  assign out_ch.last       = olast_r;

  a_upd_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    upd_r |-> (state_r == mer_pkg::BK_EMIT))
    else $error("pending error update outside emit");

  a_pop_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == mer_pkg::BK_WAIT))
    else $error("queue popped while a step is in flight");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && okind_r == mer_pkg::KIND_DONE) |-> olast_r)
    else $error("done beat without last");

  a_fill_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mer_pkg::BK_EMIT && mode_r != mer_pkg::EM_OUTLINE) |-> !idx_r[1])
    else $error("emit index beyond span or done count");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == mer_pkg::PH_DONE && !q_pop) |=> (phase_r == mer_pkg::PH_DONE))
    else $error("finished ellipse resumed without a start");

endmodule

/* sv/midpoint_ellipse_rasterizer.sv */
// Midpoint ellipse rasterizer, two regions.
// in_ch: valid/ready beats carrying action, center, radii, fill_mode, colour.
//   A start beat (action 0) latches the ellipse and gives no result; a step
//   beat (action 1) gives 4 pixels (outline) or 2 vertical spans (fill),
//   or a single done beat when idle or finished. last marks a step's final beat.
// out_ch: valid/ready result beats from a registered output stage.
// Input beats go to a 2-deep command queue, so in_ch keeps taking beats while
// results wait on out_ch; in_ch.ready drops only when the queue is full.
// The back end's sequencer fetches a command, evaluates the next point (a step
// that crosses into region two evaluates twice), then emits one beat per cycle
// while out_ch can take it; a start beat is only fetched and latched. The
// back end fetches the next command only after a step's last beat.
// Reset (rst_n low, synchronous): queue empty, no ellipse, colour 0, no
// output beat pending. A stalled out_ch holds its beat; the back end waits
// and the queue fills, after which in_ch stalls too.
module midpoint_ellipse_rasterizer (
  input logic        clk,
  input logic        rst_n,
  mer_in_if.sink     in_ch,
  mer_out_if.source  out_ch
);

  mer_pkg::cmd_t    push_cmd;
  mer_pkg::cmd_t    head_cmd;
  mer_pkg::q_stat_t q_stat;
  logic             q_push;
  logic             q_pop;

  // front: clamp radii, square them, classify start vs step
  mer_front u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  // decoupling queue
  mer_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head_cmd),
    .stat     (q_stat)
  );

  // back: error-term walk and result sequencing
  mer_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head_cmd),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

/* tb/sv/testbench.sv */
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 250;
  localparam int SETTLE       = 20;
  localparam int RANDOM_ITEMS = 90;
  localparam int IDLE_PCT     = 11;

  // One accepted command beat
  typedef struct {
    mer_pkg::action_t action;
    logic [9:0] cx;
    logic [9:0] cy;
    logic [7:0] rx;
    logic [7:0] ry;
    logic       fill;
    logic [7:0] col;
  } cmd_beat_t;

  // One expected raster beat
  typedef struct {
    mer_pkg::kind_t kind;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [11:0] end_y;
    logic [7:0]  colour;
    logic        last;
  } raster_beat_t;

  // Tracks the ellipse walk and holds the raster beats still owed by the block
  class raster_checker;
    mer_pkg::phase_t phase;
    int           off_x, off_y;
    int           chg_x, chg_y, err_acc, stop_x, stop_y;
    int           two_rx_sq, two_ry_sq;
    logic [9:0]   ctr_x, ctr_y;
    logic [7:0]   rad_x, rad_y, colour;
    logic         fill;
    raster_beat_t owed_beats[$];
    int           failures;

    function new();
      phase = mer_pkg::PH_IDLE;
      off_x = 0; off_y = 0;
      chg_x = 0; chg_y = 0; err_acc = 0; stop_x = 0; stop_y = 0;
      two_rx_sq = 0; two_ry_sq = 0;
      ctr_x = '0; ctr_y = '0; rad_x = '0; rad_y = '0; colour = '0; fill = 1'b0;
      failures = 0;
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction

    function bit finished();
      return phase == mer_pkg::PH_DONE;
    endfunction

    function void owe(mer_pkg::kind_t k, int x, int y, int ey, logic lst);
      raster_beat_t r;
      r.kind   = k;
      r.pos_x  = x[11:0];
      r.pos_y  = y[11:0];
      r.end_y  = ey[11:0];
      r.colour = colour;
      r.last   = lst;
      owed_beats.push_back(r);
    endfunction

    // Mirrors the current offset into four pixels or two vertical spans
    function void plot_point();
      int cx, cy;
      cx = int'(ctr_x);
      cy = int'(ctr_y);
      if (fill) begin
        owe(mer_pkg::KIND_SPAN, cx + off_x, cy + off_y, cy - off_y, 1'b0);
        owe(mer_pkg::KIND_SPAN, cx - off_x, cy + off_y, cy - off_y, 1'b1);
      end else begin
        owe(mer_pkg::KIND_PIXEL, cx + off_x, cy + off_y, cy + off_y, 1'b0);
        owe(mer_pkg::KIND_PIXEL, cx - off_x, cy + off_y, cy + off_y, 1'b0);
        owe(mer_pkg::KIND_PIXEL, cx - off_x, cy - off_y, cy - off_y, 1'b0);
        owe(mer_pkg::KIND_PIXEL, cx + off_x, cy - off_y, cy - off_y, 1'b1);
      end
    endfunction

    function void note_beat(cmd_beat_t b);
      int rx, ry;
      if (b.action == mer_pkg::ACT_START) begin
        rx = (int'(b.rx) > mer_pkg::MAX_RADIUS) ? mer_pkg::MAX_RADIUS : int'(b.rx);
        ry = (int'(b.ry) > mer_pkg::MAX_RADIUS) ? mer_pkg::MAX_RADIUS : int'(b.ry);
        ctr_x = b.cx;
        ctr_y = b.cy;
        rad_x = rx[7:0];
        rad_y = ry[7:0];
        fill = b.fill;
        colour = b.col;
        two_rx_sq = 2 * rx * rx;
        two_ry_sq = 2 * ry * ry;
        off_x = rx;
        off_y = 0;
        chg_x = ry * ry * (1 - 2 * rx);
        chg_y = rx * rx;
        err_acc = 0;
        stop_x = two_ry_sq * rx;
        stop_y = 0;
        phase = mer_pkg::PH_R1;
        return;
      end
      rx = int'(rad_x);
      ry = int'(rad_y);
      if (phase == mer_pkg::PH_R1) begin
        // degenerate ellipse: just the centre, once
        if (rx == 0 && ry == 0) begin
          plot_point();
          phase = mer_pkg::PH_DONE;
          return;
        end
        if (stop_x >= stop_y) begin
          plot_point();
          off_y++;
          stop_y += two_rx_sq;
          err_acc += chg_y;
          chg_y += two_rx_sq;
          if (2 * err_acc + chg_x > 0) begin
            off_x--;
            stop_x -= two_ry_sq;
            err_acc += chg_x;
            chg_x += two_ry_sq;
          end
          return;
        end
        // stop terms crossed: set up the steep region and go on in this step
        off_x = 0;
        off_y = ry;
        chg_x = ry * ry;
        chg_y = rx * rx * (1 - 2 * ry);
        err_acc = 0;
        stop_x = 0;
        stop_y = two_rx_sq * ry;
        phase = mer_pkg::PH_R2;
      end
      if (phase == mer_pkg::PH_R2) begin
        if (stop_x <= stop_y) begin
          plot_point();
          off_x++;
          stop_x += two_ry_sq;
          err_acc += chg_x;
          chg_x += two_ry_sq;
          if (2 * err_acc + chg_y > 0) begin
            off_y--;
            stop_y -= two_rx_sq;
            err_acc += chg_y;
            chg_y += two_rx_sq;
          end
          return;
        end
        phase = mer_pkg::PH_DONE;
      end
      // idle or finished: a lone done beat
      owe(mer_pkg::KIND_DONE, 0, 0, 0, 1'b1);
    endfunction

    function void mismatch(string field, int want, int got);
      failures++;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_beat(logic [1:0] kind, logic [11:0] px, logic [11:0] py,
                             logic [11:0] ey, logic [7:0] col, logic lst);
      raster_beat_t e;
      if (owed_beats.size() == 0) begin
        failures++;
        $error("raster beat with nothing owed: kind %0d x %0d y %0d",
               kind, $signed(px), $signed(py));
        return;
      end
      e = owed_beats.pop_front();
      if (kind !== e.kind)    mismatch("kind", int'(e.kind), int'(kind));
      if (px !== e.pos_x)     mismatch("pos_x", int'($signed(e.pos_x)), int'($signed(px)));
      if (py !== e.pos_y)     mismatch("pos_y", int'($signed(e.pos_y)), int'($signed(py)));
      if (ey !== e.end_y)     mismatch("end_y", int'($signed(e.end_y)), int'($signed(ey)));
      if (col !== e.colour)   mismatch("colour_out", int'(e.colour), int'(col));
      if (lst !== e.last)     mismatch("last", int'(e.last), int'(lst));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mer_in_if  in_ch ();
  mer_out_if out_ch ();

  midpoint_ellipse_rasterizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  raster_checker board = new();

  int cycle_count = 0;
  int items_sent  = 0;
  bit quiet       = 1'b0;   // both sides stop idling while set
  bit hold_request = 1'b0;  // asks the receiver for one long stall

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("midpoint_ellipse_rasterizer regression: fail");
      $finish;
    end
  end

  // Receiver: checks each accepted raster beat, then picks ready for the next edge.
  // The one long hold lets the 2-deep command queue fill so in_ch stalls.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_ch.valid && out_ch.ready)
          board.check_beat(out_ch.kind, out_ch.pos_x, out_ch.pos_y, out_ch.end_y,
                           out_ch.colour_out, out_ch.last);
        if (hold_request && !hold_done) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
      end
    end
  end

  // Offers one command beat and returns once it is taken.
  // valid stays high into the next call unless that call idles first.
  task automatic send_beat(input mer_pkg::action_t act, input logic [9:0] cx,
                           input logic [9:0] cy,
                           input logic [7:0] rx, input logic [7:0] ry,
                           input logic fill, input logic [7:0] col);
    cmd_beat_t b;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.center_x  <= cx;
    in_ch.center_y  <= cy;
    in_ch.semi_x    <= rx;
    in_ch.semi_y    <= ry;
    in_ch.fill_mode <= fill;
    in_ch.colour    <= col;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    b.action = act;
    b.cx = cx;
    b.cy = cy;
    b.rx = rx;
    b.ry = ry;
    b.fill = fill;
    b.col = col;
    board.note_beat(b);
    items_sent++;
  endtask

  // Step beat; the other fields are don't-care, so fill them with noise
  task automatic step_beat();
    send_beat(mer_pkg::ACT_STEP, 10'($urandom), 10'($urandom), 8'($urandom),
              8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // Start an ellipse and walk it until done or max_steps, then extra steps
  task automatic draw(input logic [9:0] cx, input logic [9:0] cy,
                      input logic [7:0] rx, input logic [7:0] ry,
                      input logic fill, input logic [7:0] col,
                      input int max_steps, input int extra_steps);
    int k;
    send_beat(mer_pkg::ACT_START, cx, cy, rx, ry, fill, col);
    k = 0;
    while (!board.finished() && k < max_steps) begin
      step_beat();
      k++;
    end
    repeat (extra_steps) step_beat();
  endtask

  // Mostly small radii keep ellipses short; now and then anything up to 255
  function automatic logic [7:0] pick_radius();
    if ($urandom_range(99) < 85) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int           random_base;
    int           pick;
    int           done_n;
    logic [7:0]   rx, ry;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= mer_pkg::ACT_START;
    in_ch.center_x  <= '0;
    in_ch.center_y  <= '0;
    in_ch.semi_x    <= '0;
    in_ch.semi_y    <= '0;
    in_ch.fill_mode <= 1'b0;
    in_ch.colour    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // step while idle: done beat with reset colour
    step_beat();
    // zero radii: centre point once, then done
    draw(10'd0, 10'd0, 8'd0, 8'd0, 1'b0, 8'hFF, 64, 1);
    // largest radii at a corner: columns go negative, rows pass 1023
    draw(10'd0, 10'd1023, 8'd255, 8'd255, 1'b1, 8'h00, 3, 0);
    // restart mid-ellipse, then a small outline run to the end
    draw(10'd512, 10'd300, 8'd3, 8'd2, 1'b0, 8'hA5, 64, 1);
    // flat radius: region one has only the centre point, the steep region the rest
    draw(10'd100, 10'd900, 8'd0, 8'd5, 1'b1, 8'h5A, 64, 0);
    // zero vertical radius, outline, far right edge
    draw(10'd1023, 10'd20, 8'd4, 8'd0, 1'b0, 8'h3C, 64, 1);

    // sender stands back until every owed beat has come in
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);

    random_base = items_sent;
    hold_request = 1'b1;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      done_n = items_sent - random_base;
      quiet = (done_n >= 45) && (done_n < 80);
      pick = $urandom_range(99);
      rx = pick_radius();
      ry = pick_radius();
      if (pick < 75) begin
        // complete ellipse, big ones cut short
        draw(10'($urandom), 10'($urandom), rx, ry, 1'($urandom), 8'($urandom),
             (rx > 8'd7 || ry > 8'd7) ? $urandom_range(1, 10) : 64,
             $urandom_range(0, 2));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 3)) step_beat();
      end else begin
        // abandoned ellipse
        draw(10'($urandom), 10'($urandom), rx, ry, 1'($urandom), 8'($urandom),
             $urandom_range(0, 2), 0);
      end
    end
    quiet = 1'b0;

    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.failures == 0) begin
      $display("midpoint_ellipse_rasterizer regression: pass");
    end else begin
      $display("midpoint_ellipse_rasterizer regression: fail");
    end
    $finish;
  end

endmodule

/* midpoint_ellipse_rasterizer.f */
sv/mer_pkg.sv
sv/mer_if.sv
sv/mer_front.sv
sv/mer_queue.sv
sv/mer_back.sv
sv/midpoint_ellipse_rasterizer.sv
tb/sv/testbench.sv
